// ----- rtl/core/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

   // Write buffer depth and the widths that follow from it
   localparam int MAX_BYTES = 16;
   localparam int BUF_AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int LEN_W     = $clog2(MAX_BYTES + 1);

   // Item codes on the request channel
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   // Half-bit microsteps of the bus sequencer
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_HI = 4'd1,
      PH_START_LO = 4'd2,
      PH_WB_LO    = 4'd3,
      PH_WB_HI    = 4'd4,
      PH_WA_LO    = 4'd5,
      PH_WA_HI    = 4'd6,
      PH_WA_END   = 4'd7,
      PH_RB_HI    = 4'd8,
      PH_RB_LO    = 4'd9,
      PH_RA_LO    = 4'd10,
      PH_RA_HI    = 4'd11,
      PH_RA_END   = 4'd12,
      PH_STOP_LO  = 4'd13,
      PH_STOP_CLK = 4'd14,
      PH_STOP_END = 4'd15
   } phase_type;

   // Which byte of the transaction is on the wire
   typedef enum logic [1:0] {
      STG_ADDR_W = 2'd0,
      STG_REG    = 2'd1,
      STG_DATA   = 2'd2,
      STG_ADDR_R = 2'd3
   } stage_type;

   typedef struct packed {
      req_code_type req_type;
      logic [6:0]   dev_addr;
      logic [7:0]   reg_addr;
      logic [4:0]   byte_count;
      logic [7:0]   data_byte;
      logic         sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic       nack_error;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- rtl/core/i2cm_req_if.sv -----
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [6:0] dev_addr;
   logic [7:0] reg_addr;
   logic [4:0] byte_count;
   logic [7:0] data_byte;
   logic       sda_in;

   modport source (output valid, req_type, dev_addr, reg_addr, byte_count, data_byte,
                   sda_in, input ready);
   modport sink   (input valid, req_type, dev_addr, reg_addr, byte_count, data_byte,
                   sda_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/i2cm_rsp_if.sv -----
`default_nettype none

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       read_valid;
   logic [7:0] read_byte;
   logic       done_res;
   logic       nack_error;

   modport source (output valid, scl_out, sda_out, busy_res, read_valid, read_byte,
                   done_res, nack_error, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, read_valid, read_byte,
                   done_res, nack_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/i2c_master_register_access.sv -----
// I2C register-access master with open-drain drive outputs. Each request beat
// is one item: a tick advances the bus by one half-bit interval and reports the
// SCL/SDA drive levels (1 = released), a load appends one byte to the 16-entry
// write buffer, and a begin item starts a register write or a register read.
// Loads and begins are ignored while a transaction runs. One item is taken
// every clock cycle unless the skid stage is full; its result beat is
// registered. The rate is set by the sequencer state update; the buffer
// memory is read ahead, so its read latency never stalls the stream. A two-deep
// output stage (register plus skid) keeps requests flowing while a result
// waits. Received bytes appear with read_valid on the beat that drives their
// acknowledge bit; done_res marks the beat that completes the stop, with
// nack_error set when the first device address byte was not acknowledged.
`default_nettype none

module i2c_master_register_access
   import i2cm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   i2cm_req_if.sink   req_bus,
   i2cm_rsp_if.source rsp_bus
);

   req_item_type item;
   rsp_item_type result;
   logic         accept;
   logic         take;

   rsp_item_type out_ff,  out_in;
   logic         out_vld_ff, out_vld_in;
   rsp_item_type skid_ff, skid_in;
   logic         skid_vld_ff, skid_vld_in;

   // Request beat unpacked into the item struct
   assign item.req_type   = req_code_type'(req_bus.req_type);
   assign item.dev_addr   = req_bus.dev_addr;
   assign item.reg_addr   = req_bus.reg_addr;
   assign item.byte_count = req_bus.byte_count;
   assign item.data_byte  = req_bus.data_byte;
   assign item.sda_in     = req_bus.sda_in;

   assign req_bus.ready = !skid_vld_ff;
   assign accept        = req_bus.valid && !skid_vld_ff;
   assign take          = out_vld_ff && rsp_bus.ready;

   i2cm_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (accept),
      .item    (item),
      .result  (result)
   );

   // Output register with skid stage
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (skid_vld_ff) begin
         if (take) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_vld_ff || take) begin
            out_in     = result;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = result;
            skid_vld_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid      = out_vld_ff;
   assign rsp_bus.scl_out    = out_ff.scl_out;
   assign rsp_bus.sda_out    = out_ff.sda_out;
   assign rsp_bus.busy_res   = out_ff.busy_res;
   assign rsp_bus.read_valid = out_ff.read_valid;
   assign rsp_bus.read_byte  = out_ff.read_byte;
   assign rsp_bus.done_res   = out_ff.done_res;
   assign rsp_bus.nack_error = out_ff.nack_error;

endmodule

`default_nettype wire

// ----- rtl/core/i2cm_seq.sv -----
`default_nettype none

module i2cm_seq
   import i2cm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_en,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   // Sequencer state
   phase_type          step_ff,  step_in;
   stage_type          stage_ff, stage_in;
   logic [2:0]         bit_cnt_ff, bit_cnt_in;
   logic [LEN_W-1:0]   byte_cnt_ff, byte_cnt_in;
   logic [7:0]         shift_ff, shift_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic               is_read_ff, is_read_in;
   logic [6:0]         target_ff, target_in;
   logic [7:0]         regaddr_ff, regaddr_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in_lvl;
   logic               abort_ff, abort_in;

   // Write buffer memory, one write and one registered read port
   logic [7:0]         buf_mem [MAX_BYTES];
   logic [7:0]         rd_data_ff;
   logic [BUF_AW-1:0]  rd_addr;
   logic               buf_we;
   logic [LEN_W:0]     next_byte;

   // Prefetch the byte the next data stage needs; stage and count hold
   // steady for several beats before the acknowledge end consumes it
   assign next_byte = {1'b0, byte_cnt_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign rd_addr   = (stage_ff == STG_REG) ? '0 : next_byte[BUF_AW-1:0];
   assign buf_we    = step_en && (item.req_type == REQ_LOAD) && (step_ff == PH_IDLE)
                      && (fill_ff < LEN_W'(MAX_BYTES));

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[fill_ff[BUF_AW-1:0]] <= item.data_byte;
      end
      rd_data_ff <= buf_mem[rd_addr];
   end

   // Next state and result for the beat at hand
   always_comb begin
      step_in     = step_ff;
      stage_in    = stage_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      shift_in    = shift_ff;
      fill_in     = fill_ff;
      is_read_in  = is_read_ff;
      target_in   = target_ff;
      regaddr_in  = regaddr_ff;
      len_in      = len_ff;
      scl_in      = scl_ff;
      sda_in_lvl  = sda_ff;
      abort_in    = abort_ff;
      result      = '0;

      if (step_en) begin
         case (item.req_type)
            REQ_LOAD: begin
               if (buf_we) begin
                  fill_in = fill_ff + LEN_W'(1);
               end
            end
            REQ_WRITE, REQ_READ: begin
               if (step_ff == PH_IDLE) begin
                  target_in  = item.dev_addr;
                  regaddr_in = item.reg_addr;
                  if (32'(item.byte_count) > MAX_BYTES) begin
                     len_in = LEN_W'(MAX_BYTES);
                  end else begin
                     len_in = LEN_W'(item.byte_count);
                  end
                  is_read_in  = (item.req_type == REQ_READ);
                  stage_in    = STG_ADDR_W;
                  abort_in    = 1'b0;
                  bit_cnt_in  = '0;
                  byte_cnt_in = '0;
                  shift_in    = '0;
                  step_in     = PH_START_HI;
               end
            end
            default: begin
               // Tick: one half-bit microstep
               case (step_ff)
                  PH_IDLE: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b1;
                  end
                  PH_START_HI: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b1;
                     step_in = PH_START_LO;
                  end
                  PH_START_LO: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b0;
                     shift_in   = {target_ff, stage_ff == STG_ADDR_R};
                     bit_cnt_in = '0;
                     step_in    = PH_WB_LO;
                  end
                  PH_WB_LO: begin
                     scl_in = 1'b0; sda_in_lvl = shift_ff[7];
                     step_in = PH_WB_HI;
                  end
                  PH_WB_HI: begin
                     scl_in   = 1'b1;
                     shift_in = {shift_ff[6:0], 1'b0};
                     if (bit_cnt_ff == 3'd7) begin
                        bit_cnt_in = '0;
                        step_in    = PH_WA_LO;
                     end else begin
                        bit_cnt_in = bit_cnt_ff + 3'd1;
                        step_in    = PH_WB_LO;
                     end
                  end
                  PH_WA_LO: begin
                     scl_in = 1'b0; sda_in_lvl = 1'b1;
                     step_in = PH_WA_HI;
                  end
                  PH_WA_HI: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b1;
                     // only the first address byte is checked for ACK
                     if (stage_ff == STG_ADDR_W && item.sda_in) begin
                        abort_in = 1'b1;
                        step_in  = PH_STOP_LO;
                     end else begin
                        step_in = PH_WA_END;
                     end
                  end
                  PH_WA_END: begin
                     scl_in = 1'b0; sda_in_lvl = 1'b1;
                     case (stage_ff)
                        STG_ADDR_W: begin
                           stage_in = STG_REG;
                           shift_in = regaddr_ff;
                           step_in  = PH_WB_LO;
                        end
                        STG_REG: begin
                           if (is_read_ff) begin
                              stage_in = STG_ADDR_R;
                              step_in  = PH_START_HI;
                           end else begin
                              byte_cnt_in = '0;
                              if (len_ff == '0) begin
                                 step_in = PH_STOP_LO;
                              end else begin
                                 stage_in = STG_DATA;
                                 shift_in = rd_data_ff;
                                 step_in  = PH_WB_LO;
                              end
                           end
                        end
                        STG_DATA: begin
                           byte_cnt_in = next_byte[LEN_W-1:0];
                           if (next_byte >= {1'b0, len_ff}) begin
                              step_in = PH_STOP_LO;
                           end else begin
                              shift_in = rd_data_ff;
                              step_in  = PH_WB_LO;
                           end
                        end
                        default: begin
                           byte_cnt_in = '0;
                           shift_in    = '0;
                           step_in     = (len_ff == '0) ? PH_STOP_LO : PH_RB_HI;
                        end
                     endcase
                  end
                  PH_RB_HI: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b1;
                     shift_in = {shift_ff[6:0], item.sda_in};
                     step_in  = PH_RB_LO;
                  end
                  PH_RB_LO: begin
                     scl_in = 1'b0; sda_in_lvl = 1'b1;
                     if (bit_cnt_ff == 3'd7) begin
                        bit_cnt_in = '0;
                        step_in    = PH_RA_LO;
                     end else begin
                        bit_cnt_in = bit_cnt_ff + 3'd1;
                        step_in    = PH_RB_HI;
                     end
                  end
                  PH_RA_LO: begin
                     // ACK all but the last byte
                     scl_in     = 1'b0;
                     sda_in_lvl = !(next_byte < {1'b0, len_ff});
                     result.read_valid = 1'b1;
                     result.read_byte  = shift_ff;
                     step_in = PH_RA_HI;
                  end
                  PH_RA_HI: begin
                     scl_in  = 1'b1;
                     step_in = PH_RA_END;
                  end
                  PH_RA_END: begin
                     scl_in = 1'b0; sda_in_lvl = 1'b1;
                     byte_cnt_in = next_byte[LEN_W-1:0];
                     shift_in    = '0;
                     step_in     = (next_byte >= {1'b0, len_ff}) ? PH_STOP_LO : PH_RB_HI;
                  end
                  PH_STOP_LO: begin
                     scl_in = 1'b0; sda_in_lvl = 1'b0;
                     step_in = PH_STOP_CLK;
                  end
                  PH_STOP_CLK: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b0;
                     step_in = PH_STOP_END;
                  end
                  PH_STOP_END: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b1;
                     result.done_res   = 1'b1;
                     result.nack_error = abort_ff;
                     abort_in = 1'b0;
                     if (!is_read_ff) begin
                        fill_in = '0;
                     end
                     step_in = PH_IDLE;
                  end
                  default: begin
                     scl_in = 1'b1; sda_in_lvl = 1'b1;
                     step_in = PH_IDLE;
                  end
               endcase
            end
         endcase
      end

      result.scl_out  = scl_in;
      result.sda_out  = sda_in_lvl;
      result.busy_res = (step_in != PH_IDLE);
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= PH_IDLE;
         stage_ff    <= STG_ADDR_W;
         bit_cnt_ff  <= '0;
         byte_cnt_ff <= '0;
         shift_ff    <= '0;
         fill_ff     <= '0;
         is_read_ff  <= 1'b0;
         target_ff   <= '0;
         regaddr_ff  <= '0;
         len_ff      <= '0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         abort_ff    <= 1'b0;
      end else begin
         step_ff     <= step_in;
         stage_ff    <= stage_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_cnt_ff <= byte_cnt_in;
         shift_ff    <= shift_in;
         fill_ff     <= fill_in;
         is_read_ff  <= is_read_in;
         target_ff   <= target_in;
         regaddr_ff  <= regaddr_in;
         len_ff      <= len_in;
         scl_ff      <= scl_in;
         sda_ff      <= sda_in_lvl;
         abort_ff    <= abort_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/i2cm_checker.sv -----
`default_nettype none

module i2cm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic scl_out,
   input wire logic sda_out,
   input wire logic busy_res,
   input wire logic read_valid,
   input wire logic done_res,
   input wire logic nack_error
);

   // A finished transaction leaves the block idle with both lines released
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !busy_res && scl_out && sda_out)
      else $error("done beat not idle with lines released");

   // An address error is only reported on the finishing beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && nack_error |-> done_res)
      else $error("nack_error without done_res");

   // Received bytes come out during a transaction with SCL held low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && read_valid |-> busy_res && !scl_out && !done_res)
      else $error("read byte outside an acknowledge slot");

   // A stalled result beat holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(scl_out) && $stable(sda_out)
         && $stable(busy_res) && $stable(done_res))
      else $error("result beat changed while stalled");

endmodule

bind i2c_master_register_access i2cm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .scl_out    (rsp_bus.scl_out),
   .sda_out    (rsp_bus.sda_out),
   .busy_res   (rsp_bus.busy_res),
   .read_valid (rsp_bus.read_valid),
   .done_res   (rsp_bus.done_res),
   .nack_error (rsp_bus.nack_error)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
module tb_top;
   import i2cm_pkg::*;

   localparam int N_ITEMS     = 1250;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN       = 40;

   // Result beats that can be read off at a glance
   localparam rsp_item_type LINES_IDLE = '{scl_out: 1'b1, sda_out: 1'b1, default: '0};
   localparam rsp_item_type LINES_HELD = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                           default: '0};
   localparam rsp_item_type START_LOW  = '{scl_out: 1'b1, sda_out: 1'b0, busy_res: 1'b1,
                                           default: '0};

   typedef struct {
      req_item_type it;
      bit           typed;
      rsp_item_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   i2cm_req_if req_bus ();
   i2cm_rsp_if rsp_bus ();

   i2c_master_register_access u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the bus sequencer
   phase_type  ph = PH_IDLE;
   stage_type  stage = STG_ADDR_W;
   int         bit_idx = 0;
   int         byte_idx = 0;
   logic [7:0] shifter = '0;
   logic [7:0] wbuf [MAX_BYTES];
   int         fill = 0;
   bit         rd_mode = 1'b0;
   logic [6:0] tgt_addr = '0;
   logic [7:0] reg_byte = '0;
   int         xfer_len = 0;
   logic       scl_lvl = 1'b1;
   logic       sda_lvl = 1'b1;
   bit         aborted = 1'b0;

   rsp_item_type bus_states_q [$];
   dir_row_type  dir_rows [$];

   int errors = 0;
   int item_cnt = 0;
   int n_checked = 0;
   int n_writes = 0;
   int n_reads = 0;
   int n_nacks = 0;
   int n_rbytes = 0;
   int hi_water = 0;     // buffer entries written at least once since reset
   int req_mode = 1;
   int rsp_mode = 1;
   int stall_left = 0;
   int cycles = 0;
   rsp_item_type got_beat, want_beat;

   function automatic req_item_type mk_item(req_code_type code, int dev, int regb, int cnt,
                                            int data, int sda);
      req_item_type r;
      r.req_type   = code;
      r.dev_addr   = dev[6:0];
      r.reg_addr   = regb[7:0];
      r.byte_count = cnt[4:0];
      r.data_byte  = data[7:0];
      r.sda_in     = sda[0];
      return r;
   endfunction

   // 0: no waiting, 1: uniform 0..17, 2: mostly back to back
   function automatic int draw_wait(int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 17);
         default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
      endcase
   endfunction

   // One half-bit microstep (or a load/begin) and the line state it leaves
   function automatic rsp_item_type advance_bus(input req_item_type it);
      rsp_item_type r;
      r = '0;
      case (it.req_type)
         REQ_LOAD: begin
            if (ph == PH_IDLE && fill < MAX_BYTES) begin
               wbuf[fill] = it.data_byte;
               fill++;
            end
         end
         REQ_WRITE, REQ_READ: begin
            if (ph == PH_IDLE) begin
               tgt_addr = it.dev_addr;
               reg_byte = it.reg_addr;
               xfer_len = (it.byte_count > MAX_BYTES) ? MAX_BYTES : it.byte_count;
               rd_mode  = (it.req_type == REQ_READ);
               stage    = STG_ADDR_W;
               aborted  = 1'b0;
               bit_idx  = 0;
               byte_idx = 0;
               shifter  = '0;
               ph       = PH_START_HI;
            end
         end
         default: begin
            case (ph)
               PH_IDLE: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
               end
               PH_START_HI: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  ph = PH_START_LO;
               end
               PH_START_LO: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b0;
                  shifter = {tgt_addr, stage == STG_ADDR_R};
                  bit_idx = 0;
                  ph = PH_WB_LO;
               end
               PH_WB_LO: begin
                  scl_lvl = 1'b0;
                  sda_lvl = shifter[7];
                  ph = PH_WB_HI;
               end
               PH_WB_HI: begin
                  scl_lvl = 1'b1;
                  shifter = shifter << 1;
                  if (bit_idx >= 7) begin
                     bit_idx = 0;
                     ph = PH_WA_LO;
                  end else begin
                     bit_idx++;
                     ph = PH_WB_LO;
                  end
               end
               PH_WA_LO: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  ph = PH_WA_HI;
               end
               PH_WA_HI: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  // only the first address byte's acknowledge matters
                  if (stage == STG_ADDR_W && it.sda_in) begin
                     aborted = 1'b1;
                     ph = PH_STOP_LO;
                  end else begin
                     ph = PH_WA_END;
                  end
               end
               PH_WA_END: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  case (stage)
                     STG_ADDR_W: begin
                        stage = STG_REG;
                        shifter = reg_byte;
                        ph = PH_WB_LO;
                     end
                     STG_REG: begin
                        if (rd_mode) begin
                           stage = STG_ADDR_R;
                           ph = PH_START_HI;
                        end else begin
                           byte_idx = 0;
                           if (xfer_len == 0) begin
                              ph = PH_STOP_LO;
                           end else begin
                              stage = STG_DATA;
                              shifter = wbuf[0];
                              ph = PH_WB_LO;
                           end
                        end
                     end
                     STG_DATA: begin
                        byte_idx++;
                        if (byte_idx >= xfer_len) begin
                           ph = PH_STOP_LO;
                        end else begin
                           shifter = wbuf[byte_idx];
                           ph = PH_WB_LO;
                        end
                     end
                     default: begin
                        byte_idx = 0;
                        shifter = '0;
                        ph = (xfer_len == 0) ? PH_STOP_LO : PH_RB_HI;
                     end
                  endcase
               end
               PH_RB_HI: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  shifter = {shifter[6:0], it.sda_in};
                  ph = PH_RB_LO;
               end
               PH_RB_LO: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  if (bit_idx >= 7) begin
                     bit_idx = 0;
                     ph = PH_RA_LO;
                  end else begin
                     bit_idx++;
                     ph = PH_RB_HI;
                  end
               end
               PH_RA_LO: begin
                  // ACK all but the last byte, NACK the last
                  scl_lvl = 1'b0;
                  sda_lvl = (byte_idx + 1 < xfer_len) ? 1'b0 : 1'b1;
                  r.read_valid = 1'b1;
                  r.read_byte = shifter;
                  ph = PH_RA_HI;
               end
               PH_RA_HI: begin
                  scl_lvl = 1'b1;
                  ph = PH_RA_END;
               end
               PH_RA_END: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b1;
                  byte_idx++;
                  shifter = '0;
                  ph = (byte_idx >= xfer_len) ? PH_STOP_LO : PH_RB_HI;
               end
               PH_STOP_LO: begin
                  scl_lvl = 1'b0;
                  sda_lvl = 1'b0;
                  ph = PH_STOP_CLK;
               end
               PH_STOP_CLK: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b0;
                  ph = PH_STOP_END;
               end
               PH_STOP_END: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  r.done_res = 1'b1;
                  r.nack_error = aborted;
                  aborted = 1'b0;
                  if (!rd_mode) fill = 0;
                  ph = PH_IDLE;
               end
               default: begin
                  scl_lvl = 1'b1;
                  sda_lvl = 1'b1;
                  ph = PH_IDLE;
               end
            endcase
         end
      endcase
      r.scl_out  = scl_lvl;
      r.sda_out  = sda_lvl;
      r.busy_res = (ph != PH_IDLE);
      return r;
   endfunction

   // Drive one request beat after a random gap, then record what it should produce
   task automatic send(input req_item_type it, input bit typed, input rsp_item_type want);
      int gap;
      bit ignored;
      rsp_item_type r;
      if ($urandom_range(0, 49) == 0) req_mode = $urandom_range(0, 2);
      gap = draw_wait(req_mode);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= it.req_type;
      req_bus.dev_addr   <= it.dev_addr;
      req_bus.reg_addr   <= it.reg_addr;
      req_bus.byte_count <= it.byte_count;
      req_bus.data_byte  <= it.data_byte;
      req_bus.sda_in     <= it.sda_in;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));

      ignored = (it.req_type != REQ_TICK) &&
                (ph != PH_IDLE || (it.req_type == REQ_LOAD && fill >= MAX_BYTES));
      if (!ignored) begin
         item_cnt++;
         if (it.req_type == REQ_WRITE) n_writes++;
         if (it.req_type == REQ_READ) n_reads++;
      end
      r = advance_bus(it);
      if (fill > hi_water) hi_water = fill;
      if (r.nack_error) n_nacks++;
      if (r.read_valid) n_rbytes++;
      bus_states_q.push_back(typed ? want : r);
   endtask

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (act_v !== exp_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
   endtask

   // Result side: compare each beat with the oldest expectation, then stall at random
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_beat.scl_out    = rsp_bus.scl_out;
            got_beat.sda_out    = rsp_bus.sda_out;
            got_beat.busy_res   = rsp_bus.busy_res;
            got_beat.read_valid = rsp_bus.read_valid;
            got_beat.read_byte  = rsp_bus.read_byte;
            got_beat.done_res   = rsp_bus.done_res;
            got_beat.nack_error = rsp_bus.nack_error;
            if (bus_states_q.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected, got %p", $time, got_beat);
            end else begin
               want_beat = bus_states_q.pop_front();
               n_checked++;
               check_field("scl_out", want_beat.scl_out, got_beat.scl_out);
               check_field("sda_out", want_beat.sda_out, got_beat.sda_out);
               check_field("busy_res", want_beat.busy_res, got_beat.busy_res);
               check_field("read_valid", want_beat.read_valid, got_beat.read_valid);
               check_field("read_byte", want_beat.read_byte, got_beat.read_byte);
               check_field("done_res", want_beat.done_res, got_beat.done_res);
               check_field("nack_error", want_beat.nack_error, got_beat.nack_error);
            end
            if ($urandom_range(0, 39) == 0) rsp_mode = $urandom_range(0, 2);
            stall_left = draw_wait(rsp_mode);
            if (stall_left > 0) rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) rsp_bus.ready <= 1'b1;
         end
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d result beats still outstanding", $time,
                  bus_states_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      int plan_loads;
      bit plan_begin;
      bit plan_rd;
      int plan_cnt;
      int sat_cnt;
      int pick;

      plan_loads = 0;
      plan_begin = 1'b0;
      plan_rd    = 1'b0;
      plan_cnt   = 0;
      foreach (wbuf[k]) wbuf[k] = '0;

      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_TICK;
      req_bus.dev_addr   <= '0;
      req_bus.reg_addr   <= '0;
      req_bus.byte_count <= '0;
      req_bus.data_byte  <= '0;
      req_bus.sda_in     <= 1'b0;

      // Directed rows: idle ticks, loads at the data extremes, a saturated read with
      // extreme addresses, load and begin while busy, then the start and address bits
      dir_rows.push_back('{mk_item(REQ_TICK, 0, 0, 0, 0, 0), 1'b1, LINES_IDLE});
      dir_rows.push_back('{mk_item(REQ_TICK, 127, 255, 31, 255, 1), 1'b1, LINES_IDLE});
      dir_rows.push_back('{mk_item(REQ_LOAD, 0, 0, 0, 8'h00, 0), 1'b1, LINES_IDLE});
      dir_rows.push_back('{mk_item(REQ_LOAD, 0, 0, 0, 8'hFF, 0), 1'b1, LINES_IDLE});
      dir_rows.push_back('{mk_item(REQ_LOAD, 0, 0, 0, 8'h5A, 0), 1'b1, LINES_IDLE});
      dir_rows.push_back('{mk_item(REQ_READ, 127, 255, 31, 0, 0), 1'b1, LINES_HELD});
      dir_rows.push_back('{mk_item(REQ_LOAD, 0, 0, 0, 8'h3C, 0), 1'b1, LINES_HELD});
      dir_rows.push_back('{mk_item(REQ_WRITE, 0, 0, 0, 0, 0), 1'b1, LINES_HELD});
      dir_rows.push_back('{mk_item(REQ_TICK, 0, 0, 0, 0, 1), 1'b1, LINES_HELD});
      dir_rows.push_back('{mk_item(REQ_TICK, 0, 0, 0, 0, 0), 1'b1, START_LOW});
      for (int k = 0; k < 14; k++)
         dir_rows.push_back('{mk_item(REQ_TICK, 0, 0, 0, 0, k % 2), 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

      // Random part: mostly complete transactions, some noise while busy
      while (item_cnt < N_ITEMS || ph != PH_IDLE) begin
         it = mk_item(REQ_TICK, $urandom_range(0, 127), $urandom_range(0, 255),
                      $urandom_range(0, 31), $urandom_range(0, 255), $urandom_range(0, 1));
         if (ph != PH_IDLE) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               it.req_type = REQ_LOAD;
            end else if (pick < 4) begin
               it.req_type = REQ_WRITE;
            end else if (pick < 5) begin
               it.req_type = REQ_READ;
            end else if (ph == PH_WA_HI && stage == STG_ADDR_W) begin
               it.sda_in = ($urandom_range(0, 99) < 12);
            end
         end else begin
            if (!plan_begin && $urandom_range(0, 9) != 0) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) plan_cnt = $urandom_range(0, 2);
               else if (pick < 90) plan_cnt = $urandom_range(3, 8);
               else plan_cnt = $urandom_range(9, 31);
               sat_cnt = (plan_cnt > MAX_BYTES) ? MAX_BYTES : plan_cnt;
               plan_rd = ($urandom_range(0, 99) < 45);
               // a write may only reach entries that were loaded at some point
               plan_loads = (!plan_rd && sat_cnt > hi_water) ? sat_cnt - fill : 0;
               if ($urandom_range(0, 3) == 0) plan_loads += $urandom_range(1, 4);
               plan_begin = 1'b1;
            end
            if (plan_loads > 0) begin
               it.req_type = REQ_LOAD;
               pick = $urandom_range(0, 9);
               if (pick == 0) it.data_byte = 8'h00;
               else if (pick == 1) it.data_byte = 8'hFF;
               plan_loads--;
            end else if (plan_begin) begin
               it.req_type = plan_rd ? REQ_READ : REQ_WRITE;
               it.byte_count = plan_cnt[4:0];
               plan_begin = 1'b0;
            end
         end
         send(it, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      while (bus_states_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("Run covered %0d accepted items and %0d checked result beats.",
               item_cnt, n_checked);
      $display("Transactions: %0d writes, %0d reads, %0d address NACKs, %0d bytes read back.",
               n_writes, n_reads, n_nacks, n_rbytes);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
